// File: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components block.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    // Vertex limit and derived widths.
    localparam int MAX_VERTICES = 32;
    localparam int VLIMIT       = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int VW           = 5;   // vertex index width
    localparam int CW           = 6;   // count width
    localparam int SW           = 7;   // finish stamp width
    localparam int LW           = 6;   // label width
    localparam int RW           = 32;  // adjacency row width

    typedef logic [VW-1:0] vidx_t;
    typedef logic [CW-1:0] count_t;
    typedef logic [SW-1:0] stamp_t;
    typedef logic [LW-1:0] label_t;
    typedef logic [RW-1:0] row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P1_ROOT,
        ST_P1_STEP,
        ST_P2_SCAN,
        ST_P2_STEP,
        ST_EMIT
    } state_t;

    // Control broadcast from the sequencer to every lane.
    typedef struct packed {
        count_t count;       // vertices in use
        logic   transposed;  // second pass reads columns
        vidx_t  top;         // vertex on top of the stack
        logic   clear;       // mark every lane unvisited
        logic   hit_en;      // discover vertex hit
        vidx_t  hit;
        logic   labeling;    // write label on discovery
        label_t label;
        logic   fin_en;      // stamp vertex fin
        vidx_t  fin;
        stamp_t fin_stamp;
    } lane_ctrl_t;

    // Result of merging lane candidates.
    typedef struct packed {
        logic  any;
        vidx_t idx;
    } merge_t;

endpackage

`default_nettype wire

// File: rtl/scc_if.sv
// ----------------------------------------------------------------------------
// scc_row_if / scc_res_if
// Valid-ready channels for adjacency rows in and component results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_row_if;
    logic          valid;
    logic          ready;
    scc_pkg::vidx_t row_index;
    scc_pkg::row_t  row_edges;
    logic          last_row;

    modport source (output valid, output row_index, output row_edges,
                    output last_row, input ready);
    modport sink   (input valid, input row_index, input row_edges,
                    input last_row, output ready);
endinterface

interface scc_res_if;
    logic           valid;
    logic           ready;
    scc_pkg::vidx_t  vertex;
    scc_pkg::label_t component;
    logic           last_result;

    modport source (output valid, output vertex, output component,
                    output last_result, input ready);
    modport sink   (input valid, input vertex, input component,
                    input last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/scc_lane.sv
// ----------------------------------------------------------------------------
// scc_lane
// One vertex lane: visited flag, finish stamp, label and edge candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scc_pkg::vidx_t     lane_id,
    input  wire scc_pkg::lane_ctrl_t ctrl,
    input  wire scc_pkg::row_t      own_row,
    input  wire scc_pkg::row_t      top_row,
    output logic                    cand,
    output logic                    white,
    output scc_pkg::stamp_t         stamp,
    output scc_pkg::label_t         label
);

    logic            visited_reg, visited_next;
    scc_pkg::stamp_t stamp_reg, stamp_next;
    scc_pkg::label_t label_reg;
    logic            active, edge_bit, is_hit;

    // Lane is in use when its index is below the vertex count.
    assign active   = ({1'b0, lane_id} < ctrl.count);
    assign edge_bit = ctrl.transposed ? own_row[ctrl.top] : top_row[lane_id];
    assign white    = active && !visited_reg;
    assign cand     = white && edge_bit;
    assign is_hit   = ctrl.hit_en && (ctrl.hit == lane_id);

    // Visited flag and finish stamp updates.
    always_comb
    begin
        visited_next = visited_reg;
        stamp_next   = stamp_reg;
        if (ctrl.clear)
            visited_next = 1'b0;
        else if (is_hit)
            visited_next = 1'b1;
        if (ctrl.fin_en && (ctrl.fin == lane_id))
            stamp_next = ctrl.fin_stamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= 1'b0;
            stamp_reg   <= '0;
        end
        else
        begin
            visited_reg <= visited_next;
            stamp_reg   <= stamp_next;
        end
    end

    // Label is written when the second pass discovers this vertex.
    always_ff @(posedge clk)
    begin
        if (is_hit && ctrl.labeling)
            label_reg <= ctrl.label;
    end

    assign stamp = stamp_reg;
    assign label = label_reg;

endmodule

`default_nettype wire

// File: rtl/scc_merge.sv
// ----------------------------------------------------------------------------
// scc_merge
// Picks the lowest-index lane that reports a candidate edge.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_merge (
    input  wire logic [scc_pkg::VLIMIT-1:0] cand,
    output scc_pkg::merge_t                 result
);

    // Priority encoder, lowest index wins.
    always_comb
    begin
        result.any = 1'b0;
        result.idx = '0;
        for (int v = scc_pkg::VLIMIT - 1; v >= 0; v--)
        begin
            if (cand[v])
            begin
                result.any = 1'b1;
                result.idx = scc_pkg::vidx_t'(v);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/strongly_connected_components.sv
// ----------------------------------------------------------------------------
// strongly_connected_components
// Kosaraju component labeling of a directed graph loaded as adjacency rows.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Payload
//  rows      in   valid/ready      row_index, row_edges, last_row
//  results   out  valid/ready      vertex, component, last_result
//  cfg       in   cfg_we           cfg_wdata (vertex_count)
//
// A last row starts both searches: the first pass walks the roots in index
// order, and each search step discovers or finishes one vertex; the second
// pass picks each root by a scan of the lane stamps, with one closing empty
// scan. Then N results follow at one per cycle while the output is not stalled.
// Reset clears control state; stored rows are undefined until written.
// Output stalls only hold the emit sequencer; rows are refused while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module strongly_connected_components (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire scc_pkg::count_t     cfg_wdata,
    scc_row_if.sink                  rows,
    scc_res_if.source                results
);

    localparam int NV = scc_pkg::VLIMIT;

    scc_pkg::state_t state_reg, state_next;
    scc_pkg::count_t vcount_reg, n_reg, n_next;
    scc_pkg::count_t scan_reg, scan_next;      // root index / stamp scan / emit
    scc_pkg::count_t sp_reg, sp_next;
    scc_pkg::vidx_t  top_reg, top_next;
    scc_pkg::stamp_t time_reg, time_next;
    scc_pkg::label_t lab_reg, lab_next;
    scc_pkg::stamp_t best_reg, best_next;
    scc_pkg::vidx_t  root_reg, root_next;
    logic            any_reg, any_next;
    scc_pkg::row_t   row_mem [NV];
    scc_pkg::vidx_t  stack_mem [NV];

    logic            push, pop, out_load, out_valid_reg;
    scc_pkg::vidx_t  push_v, out_vertex_reg;
    scc_pkg::label_t out_comp_reg;
    logic            out_last_reg;
    scc_pkg::lane_ctrl_t ctrl;
    scc_pkg::merge_t merged;
    scc_pkg::count_t n_cfg;

    logic [NV-1:0]   cand, white;
    scc_pkg::stamp_t stamps [NV];
    scc_pkg::label_t labels [NV];
    scc_pkg::vidx_t  scan_idx;
    logic            row_acc;

    assign row_acc  = rows.valid && rows.ready;
    assign rows.ready = (state_reg == scc_pkg::ST_IDLE);
    assign scan_idx = scan_reg[scc_pkg::VW-1:0];

    // Clamp the configured vertex count to 1..VLIMIT.
    always_comb
    begin
        if (vcount_reg == '0)
            n_cfg = scc_pkg::count_t'(1);
        else if (vcount_reg > scc_pkg::count_t'(NV))
            n_cfg = scc_pkg::count_t'(NV);
        else
            n_cfg = vcount_reg;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= scc_pkg::count_t'(32);
        else if (cfg_we)
            vcount_reg <= cfg_wdata;
    end

    // Adjacency row store.
    always_ff @(posedge clk)
    begin
        if (row_acc)
            row_mem[rows.row_index] <= rows.row_edges;
    end

    // Vertex lanes and merge.
    for (genvar v = 0; v < NV; v++)
    begin : g_lane
        scc_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .lane_id (scc_pkg::vidx_t'(v)),
            .ctrl    (ctrl),
            .own_row (row_mem[v]),
            .top_row (row_mem[top_reg]),
            .cand    (cand[v]),
            .white   (white[v]),
            .stamp   (stamps[v]),
            .label   (labels[v])
        );
    end

    scc_merge u_merge (
        .cand   (cand),
        .result (merged)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scc_pkg::ST_IDLE:
                if (row_acc && rows.last_row)
                    state_next = scc_pkg::ST_P1_ROOT;
            scc_pkg::ST_P1_ROOT:
                if (scan_reg == n_reg)
                    state_next = scc_pkg::ST_P2_SCAN;
                else if (white[scan_idx])
                    state_next = scc_pkg::ST_P1_STEP;
            scc_pkg::ST_P1_STEP:
                if (!merged.any && sp_reg == scc_pkg::count_t'(1))
                    state_next = scc_pkg::ST_P1_ROOT;
            scc_pkg::ST_P2_SCAN:
                if (scan_reg == n_reg)
                    state_next = any_reg ? scc_pkg::ST_P2_STEP : scc_pkg::ST_EMIT;
            scc_pkg::ST_P2_STEP:
                if (!merged.any && sp_reg == scc_pkg::count_t'(1))
                    state_next = scc_pkg::ST_P2_SCAN;
            scc_pkg::ST_EMIT:
                if (out_load && scan_reg + scc_pkg::count_t'(1) == n_reg)
                    state_next = scc_pkg::ST_IDLE;
            default:
                state_next = scc_pkg::ST_IDLE;
        endcase
    end

    // Datapath control.
    always_comb
    begin
        n_next    = n_reg;
        scan_next = scan_reg;
        time_next = time_reg;
        lab_next  = lab_reg;
        best_next = best_reg;
        root_next = root_reg;
        any_next  = any_reg;
        push      = 1'b0;
        pop       = 1'b0;
        push_v    = '0;
        out_load  = 1'b0;

        ctrl.count      = n_reg;
        ctrl.transposed = (state_reg == scc_pkg::ST_P2_STEP);
        ctrl.top        = top_reg;
        ctrl.clear      = 1'b0;
        ctrl.hit_en     = 1'b0;
        ctrl.hit        = '0;
        ctrl.labeling   = 1'b0;
        ctrl.label      = lab_reg;
        ctrl.fin_en     = 1'b0;
        ctrl.fin        = top_reg;
        ctrl.fin_stamp  = time_reg + scc_pkg::stamp_t'(1);

        unique case (state_reg)
            scc_pkg::ST_IDLE:
                if (row_acc && rows.last_row)
                begin
                    n_next     = n_cfg;
                    ctrl.clear = 1'b1;
                    time_next  = '0;
                    scan_next  = '0;
                end
            scc_pkg::ST_P1_ROOT:
                if (scan_reg == n_reg)
                begin
                    // Start the second pass.
                    ctrl.clear = 1'b1;
                    scan_next  = '0;
                    best_next  = '0;
                    any_next   = 1'b0;
                    lab_next   = scc_pkg::label_t'(1);
                end
                else if (white[scan_idx])
                begin
                    push      = 1'b1;
                    push_v    = scan_idx;
                    time_next = time_reg + scc_pkg::stamp_t'(1);
                end
                else
                    scan_next = scan_reg + scc_pkg::count_t'(1);
            scc_pkg::ST_P1_STEP:
                if (merged.any)
                begin
                    push      = 1'b1;
                    push_v    = merged.idx;
                    time_next = time_reg + scc_pkg::stamp_t'(1);
                end
                else
                begin
                    pop         = 1'b1;
                    ctrl.fin_en = 1'b1;
                    time_next   = time_reg + scc_pkg::stamp_t'(1);
                end
            scc_pkg::ST_P2_SCAN:
                if (scan_reg == n_reg)
                begin
                    if (any_reg)
                    begin
                        push   = 1'b1;
                        push_v = root_reg;
                    end
                    else
                        scan_next = '0;
                end
                else
                begin
                    if (white[scan_idx] && stamps[scan_idx] > best_reg)
                    begin
                        best_next = stamps[scan_idx];
                        root_next = scan_idx;
                        any_next  = 1'b1;
                    end
                    scan_next = scan_reg + scc_pkg::count_t'(1);
                end
            scc_pkg::ST_P2_STEP:
                if (merged.any)
                begin
                    push   = 1'b1;
                    push_v = merged.idx;
                end
                else
                begin
                    pop = 1'b1;
                    if (sp_reg == scc_pkg::count_t'(1))
                    begin
                        lab_next  = lab_reg + scc_pkg::label_t'(1);
                        scan_next = '0;
                        best_next = '0;
                        any_next  = 1'b0;
                    end
                end
            scc_pkg::ST_EMIT:
                if (!out_valid_reg || results.ready)
                begin
                    out_load  = 1'b1;
                    scan_next = scan_reg + scc_pkg::count_t'(1);
                end
            default:
                ;
        endcase

        // Discovery marks the lane and writes its label in the second pass.
        ctrl.hit_en   = push;
        ctrl.hit      = push_v;
        ctrl.labeling = push && (state_reg == scc_pkg::ST_P2_SCAN
                                 || state_reg == scc_pkg::ST_P2_STEP);
    end

    // Search stack with a separate top-of-stack register.
    always_comb
    begin
        sp_next  = sp_reg;
        top_next = top_reg;
        if (push)
        begin
            sp_next  = sp_reg + scc_pkg::count_t'(1);
            top_next = push_v;
        end
        else if (pop)
        begin
            sp_next = sp_reg - scc_pkg::count_t'(1);
            if (sp_reg > scc_pkg::count_t'(1))
                top_next = stack_mem[scc_pkg::vidx_t'(sp_reg - scc_pkg::count_t'(2))];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[sp_reg[scc_pkg::VW-1:0]] <= push_v;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_IDLE;
            n_reg     <= scc_pkg::count_t'(1);
            scan_reg  <= '0;
            sp_reg    <= '0;
            top_reg   <= '0;
            time_reg  <= '0;
            lab_reg   <= scc_pkg::label_t'(1);
            best_reg  <= '0;
            root_reg  <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            scan_reg  <= scan_next;
            sp_reg    <= sp_next;
            top_reg   <= top_next;
            time_reg  <= time_next;
            lab_reg   <= lab_next;
            best_reg  <= best_next;
            root_reg  <= root_next;
            any_reg   <= any_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_vertex_reg <= scan_idx;
            out_comp_reg   <= labels[scan_idx];
            out_last_reg   <= (scan_reg + scc_pkg::count_t'(1) == n_reg);
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.vertex      = out_vertex_reg;
    assign results.component   = out_comp_reg;
    assign results.last_result = out_last_reg;

    // The stack never holds more vertices than are in use.
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= n_reg)
        else $error("search stack overflow");

    // A search step always has a vertex on the stack.
    a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scc_pkg::ST_P1_STEP || state_reg == scc_pkg::ST_P2_STEP)
        |-> sp_reg != '0)
        else $error("search step with empty stack");

    // Every reported label was written by the second pass.
    a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.component != '0)
        else $error("zero component label");

    // Every first-pass step, push or pop, advances the time counter by one.
    a_time_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scc_pkg::ST_P1_STEP) |=> time_reg == $past(time_reg) + 7'd1)
        else $error("time counter did not step");

endmodule

`default_nettype wire
